// File: hw/rtl/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types and constants for the tone/noise sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

  // input operation codes
  localparam logic [2:0] OP_PORT_A = 3'd0;
  localparam logic [2:0] OP_PORT_B = 3'd1;
  localparam logic [2:0] OP_ADDR   = 3'd2;
  localparam logic [2:0] OP_WRITE  = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;
  localparam logic [2:0] OP_TICK   = 3'd5;

  // bridge modes that act
  localparam logic [1:0] MODE_WRITE  = 2'd2;
  localparam logic [1:0] MODE_SELECT = 2'd3;

  // internal command kinds
  localparam logic [1:0] CMD_SEL  = 2'd0;
  localparam logic [1:0] CMD_WR   = 2'd1;
  localparam logic [1:0] CMD_RD   = 2'd2;
  localparam logic [1:0] CMD_TICK = 2'd3;

  // result kinds
  localparam logic RES_READ   = 1'b0;
  localparam logic RES_SAMPLE = 1'b1;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_AW    = $clog2(CMD_DEPTH);

  localparam int ACC_W           = 18;
  localparam int CLOCK_STEP_DEF  = 93750;
  localparam int SAMPLE_STEP_DEF = 44100;

  localparam logic [16:0] NOISE_SEED = 17'h1FFFF;
  localparam int REG_NOISE = 6;
  localparam int REG_MIXER = 7;
  localparam int REG_AMP   = 8;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } cmd_t;

endpackage

// File: hw/rtl/psg_front.sv
// ----------------------------------------------------------------------------
// psg_front
// Accepts input words, runs the parallel-port bridge, emits commands.
// ----------------------------------------------------------------------------
module psg_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic           full,
  input  logic [2:0]     operation,
  input  logic [7:0]     value,
  output logic           cmd_push,
  output psg_pkg::cmd_t  cmd
);
  import psg_pkg::*;

  logic [7:0] port_a;
  logic [1:0] bridge_mode;
  logic [1:0] mode_new;
  logic       accept;

  assign accept   = push && !full;
  assign mode_new = value[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      port_a      <= '0;
      bridge_mode <= '0;
    end else if (accept) begin
      if (operation == OP_PORT_A) begin
        port_a <= value;
      end
      if (operation == OP_PORT_B) begin
        bridge_mode <= mode_new;
      end
    end
  end

  always_comb begin
    cmd_push  = 1'b0;
    cmd.kind  = CMD_SEL;
    cmd.data  = value;
    unique case (operation)
      OP_PORT_B: begin
        if (mode_new != bridge_mode && mode_new == MODE_WRITE) begin
          cmd_push = accept;
          cmd.kind = CMD_WR;
          cmd.data = port_a;
        end else if (mode_new != bridge_mode && mode_new == MODE_SELECT) begin
          cmd_push = accept;
          cmd.kind = CMD_SEL;
          cmd.data = port_a;
        end
      end
      OP_ADDR: begin
        cmd_push = accept;
        cmd.kind = CMD_SEL;
      end
      OP_WRITE: begin
        cmd_push = accept;
        cmd.kind = CMD_WR;
      end
      OP_READ: begin
        cmd_push = accept;
        cmd.kind = CMD_RD;
      end
      OP_TICK: begin
        cmd_push = accept;
        cmd.kind = CMD_TICK;
      end
      default: begin
        cmd_push = 1'b0;
      end
    endcase
  end

endmodule

// File: hw/rtl/psg_cmd_fifo.sv
// ----------------------------------------------------------------------------
// psg_cmd_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module psg_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  psg_pkg::cmd_t  wr_cmd,
  output logic           full,
  input  logic           rd_en,
  output logic           valid,
  output psg_pkg::cmd_t  rd_cmd
);
  import psg_pkg::*;

  cmd_t              slots [CMD_DEPTH];
  logic [CMD_AW-1:0] wr_ptr;
  logic [CMD_AW-1:0] rd_ptr;
  logic [CMD_AW:0]   count;
  logic              do_wr;
  logic              do_rd;

  assign full   = (count == (CMD_AW+1)'(CMD_DEPTH));
  assign valid  = (count != '0);
  assign rd_cmd = slots[rd_ptr];
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/psg_back.sv
// ----------------------------------------------------------------------------
// psg_back
// Register file, tone/noise generators, phase accumulator, mixer, result word.
// ----------------------------------------------------------------------------
module psg_back #(
  parameter int CLOCK_STEP  = psg_pkg::CLOCK_STEP_DEF,
  parameter int SAMPLE_STEP = psg_pkg::SAMPLE_STEP_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  psg_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  output logic           empty,
  input  logic           pop,
  output logic           result_kind,
  output logic [7:0]     read_value,
  output logic [6:0]     sample_sum
);
  import psg_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [ACC_W-1:0] CSTEP = ACC_W'(CLOCK_STEP);
  localparam logic [ACC_W-1:0] SSTEP = ACC_W'(SAMPLE_STEP);

  logic              state;
  logic [7:0]        regs [16];
  logic [3:0]        selected;
  logic [11:0]       tone_count [3];
  logic [2:0]        tone_level;
  logic [5:0]        noise_count;
  logic [16:0]       noise_shift;
  logic [ACC_W-1:0]  acc;
  logic              out_valid;

  logic              out_free;
  logic              step;
  logic              read_load;
  logic              sample_load;
  logic [11:0]       tone_count_next [3];
  logic [2:0]        tone_level_next;
  logic [5:0]        noise_count_next;
  logic [16:0]       noise_shift_next;
  logic signed [6:0] mix;

  assign out_free    = !out_valid || pop;
  assign empty       = !out_valid;
  assign step        = (state == ST_RUN) && (acc >= SSTEP);
  assign sample_load = (state == ST_RUN) && !step && out_free;
  assign cmd_pop     = (state == ST_IDLE) && cmd_valid
                       && (cmd.kind != CMD_RD || out_free);
  assign read_load   = cmd_pop && (cmd.kind == CMD_RD);

  // one chip clock
  always_comb begin
    logic [11:0] period;
    logic [11:0] cur;
    logic [4:0]  np;
    logic [5:0]  ncur;
    for (int c = 0; c < 3; c++) begin
      period = {regs[2*c+1][3:0], regs[2*c]};
      cur    = (tone_count[c] != '0) ? tone_count[c]
             : ((period != '0) ? period : 12'd1);
      tone_count_next[c] = cur - 12'd1;
      tone_level_next[c] = tone_level[c] ^ (cur == 12'd1);
    end
    np   = regs[REG_NOISE][4:0];
    ncur = (noise_count != '0) ? noise_count
         : {((np != '0) ? np : 5'd1), 1'b0};
    noise_count_next = ncur - 6'd1;
    noise_shift_next = (ncur == 6'd1)
                     ? {noise_shift[0] ^ noise_shift[3], noise_shift[16:1]}
                     : noise_shift;
  end

  // mixer
  always_comb begin
    logic              on;
    logic signed [6:0] amp;
    mix = '0;
    for (int c = 0; c < 3; c++) begin
      on  = (tone_level[c] | regs[REG_MIXER][c]) & (noise_shift[0] | regs[REG_MIXER][c+3]);
      amp = signed'({3'b000, regs[REG_AMP+c][3:0]});
      mix = on ? (mix + amp) : (mix - amp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      selected    <= '0;
      tone_level  <= '0;
      noise_count <= '0;
      noise_shift <= NOISE_SEED;
      acc         <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        regs[i] <= '0;
      end
      for (int c = 0; c < 3; c++) begin
        tone_count[c] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            unique case (cmd.kind)
              CMD_SEL:  selected <= cmd.data[3:0];
              CMD_WR:   regs[selected] <= cmd.data;
              CMD_RD: begin
                result_kind <= RES_READ;
                read_value  <= regs[selected];
                sample_sum  <= '0;
              end
              CMD_TICK: begin
                acc   <= acc + CSTEP;
                state <= ST_RUN;
              end
            endcase
          end
        end
        ST_RUN: begin
          if (step) begin
            acc         <= acc - SSTEP;
            tone_level  <= tone_level_next;
            noise_count <= noise_count_next;
            noise_shift <= noise_shift_next;
            for (int c = 0; c < 3; c++) begin
              tone_count[c] <= tone_count_next[c];
            end
          end else if (out_free) begin
            result_kind <= RES_SAMPLE;
            read_value  <= '0;
            sample_sum  <= mix;
            state       <= ST_IDLE;
          end
        end
      endcase
      if (read_load || sample_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_lfsr_live: assert property (@(posedge clk) disable iff (rst) noise_shift != '0)
    else $error("noise shift register reached zero");
  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> acc < SSTEP)
    else $error("accumulator not reduced below sample step");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (read_load || sample_load) |-> (!out_valid || pop))
    else $error("pending result overwritten");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> state == ST_IDLE)
    else $error("command taken while a tick is running");

endmodule

// File: hw/rtl/psg_tone_noise_sound_generator_unit.sv
// ----------------------------------------------------------------------------
// psg_tone_noise_sound_generator_unit
// Three tone channels plus LFSR noise behind a 16-byte register file.
// ----------------------------------------------------------------------------
// Input channel: push/full with operation and value. Port A/B writes drive the
// parallel-port bridge; address latch, data write, data read and sample tick
// reach the register file and generators directly.
// Result channel: empty/pop. A data read returns read_value (kind 0); a sample
// tick returns the signed channel sum in sample_sum (kind 1).
// Accepted words go through a front decoder into a four-entry command queue,
// so the input side keeps taking words while the back end works or waits.
// A register command is carried out in the back end when it is taken. A sample
// tick adds CLOCK_STEP to the accumulator, then runs chip clocks while it holds
// at least SAMPLE_STEP (CLOCK_STEP/SAMPLE_STEP rounded up or down, 2 or 3 at the
// defaults), then mixes the channels into the result register.
// A read or tick waits while the result register holds an untaken word; the
// queue fills and full rises if pop stays low.
// Synchronous reset clears the register file, counters and the accumulator and
// seeds the noise shift register with all ones; the result outputs are not cleared.
// ----------------------------------------------------------------------------
module psg_tone_noise_sound_generator_unit #(
  parameter int CLOCK_STEP  = psg_pkg::CLOCK_STEP_DEF,
  parameter int SAMPLE_STEP = psg_pkg::SAMPLE_STEP_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [2:0] operation,
  input  logic [7:0] value,
  output logic       empty,
  input  logic       pop,
  output logic       result_kind,
  output logic [7:0] read_value,
  output logic [6:0] sample_sum
);
  import psg_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic front_push;
  logic queue_valid;
  logic queue_pop;

  psg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .operation (operation),
    .value     (value),
    .cmd_push  (front_push),
    .cmd       (front_cmd)
  );

  psg_cmd_fifo u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (front_push),
    .wr_cmd (front_cmd),
    .full   (full),
    .rd_en  (queue_pop),
    .valid  (queue_valid),
    .rd_cmd (back_cmd)
  );

  psg_back #(
    .CLOCK_STEP  (CLOCK_STEP),
    .SAMPLE_STEP (SAMPLE_STEP)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (queue_valid),
    .cmd         (back_cmd),
    .cmd_pop     (queue_pop),
    .empty       (empty),
    .pop         (pop),
    .result_kind (result_kind),
    .read_value  (read_value),
    .sample_sum  (sample_sum)
  );

endmodule

// File: sim/psg_tone_noise_sound_generator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psg_tone_noise_sound_generator_unit_tb
// Drives register, bridge and sample-tick words into the sound generator. A
// cycle-free model of the register file, tone and noise generators predicts
// each read and sample word, which is checked in order against the output.
// ----------------------------------------------------------------------------
module psg_tone_noise_sound_generator_unit_tb;
  import psg_pkg::*;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_HOLD  = 2'd1;
  localparam logic [3:0] REG_A_LO   = 4'd0;
  localparam logic [3:0] REG_C_HI   = 4'd5;
  localparam int WORDS       = 1075;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL        = 20;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] val;
    logic       drain;
  } in_word_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] rd;
    logic [6:0] sum;
  } out_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic [2:0] operation = '0;
  logic [7:0] value = '0;
  logic       full;
  logic       empty;
  logic       result_kind;
  logic [7:0] read_value;
  logic [6:0] sample_sum;

  // generator state as predicted
  logic [7:0]  regs [16];
  logic [3:0]  sel;
  logic [11:0] tcnt [3];
  logic [2:0]  tlev;
  logic [5:0]  ncnt;
  logic [16:0] nshift;
  int          acc;
  logic [7:0]  latch_a;
  logic [1:0]  bmode;

  in_word_t  send_q [$];
  out_word_t owed [$];

  int errors = 0;
  int gap_in = 0;
  int gap_out = 0;
  int stalled = 0;
  int n_words = 0;
  bit held = 1'b0;
  bit drained = 1'b0;
  bit hold_next = 1'b0;

  psg_tone_noise_sound_generator_unit dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .operation(operation),
    .value(value),
    .empty(empty),
    .pop(pop),
    .result_kind(result_kind),
    .read_value(read_value),
    .sample_sum(sample_sum)
  );

  always #5 clk = ~clk;

  task automatic psg_apply(input logic [2:0] op, input logic [7:0] val);
    out_word_t   w;
    logic [1:0]  m;
    logic [11:0] per;
    logic [4:0]  nper;
    logic        on;
    int          sum;
    w = '0;
    sum = 0;
    case (op)
      OP_PORT_A: latch_a = val;
      OP_PORT_B: begin
        m = val[4:3];
        if (m != bmode) begin
          bmode = m;
          if (m == MODE_WRITE) regs[sel] = latch_a;
          else if (m == MODE_SELECT) sel = latch_a[3:0];
        end
      end
      OP_ADDR: sel = val[3:0];
      OP_WRITE: regs[sel] = val;
      OP_READ: begin
        w.kind = RES_READ;
        w.rd = regs[sel];
        owed.push_back(w);
      end
      OP_TICK: begin
        acc += CLOCK_STEP_DEF;
        while (acc >= SAMPLE_STEP_DEF) begin
          acc -= SAMPLE_STEP_DEF;
          for (int c = 0; c < 3; c++) begin
            if (tcnt[c] == 12'd0) begin
              per = {regs[2 * c + 1][3:0], regs[2 * c]};
              tcnt[c] = (per == 12'd0) ? 12'd1 : per;
            end
            tcnt[c] = tcnt[c] - 12'd1;
            if (tcnt[c] == 12'd0) tlev[c] = ~tlev[c];
          end
          if (ncnt == 6'd0) begin
            nper = regs[REG_NOISE][4:0];
            ncnt = (nper == 5'd0) ? 6'd2 : {nper, 1'b0};
          end
          ncnt = ncnt - 6'd1;
          if (ncnt == 6'd0) nshift = {nshift[0] ^ nshift[3], nshift[16:1]};
        end
        for (int c = 0; c < 3; c++) begin
          on = (tlev[c] | regs[REG_MIXER][c]) & (nshift[0] | regs[REG_MIXER][c + 3]);
          sum += on ? int'(regs[REG_AMP + c][3:0]) : -int'(regs[REG_AMP + c][3:0]);
        end
        w.kind = RES_SAMPLE;
        w.sum = 7'(sum);
        owed.push_back(w);
      end
      default: ;
    endcase
  endtask

  task automatic add_word(input logic [2:0] op, input logic [7:0] val);
    send_q.push_back('{op: op, val: val, drain: hold_next});
    hold_next = 1'b0;
    if (op != OP_SPARE_A && op != OP_SPARE_B) n_words++;
  endtask

  function automatic logic [7:0] port_b(input logic [1:0] mode, input logic [7:0] fill);
    logic [7:0] b;
    b = fill;
    b[4:3] = mode;
    return b;
  endfunction

  // short periods half the time for period registers so tones and noise actually move
  function automatic logic [7:0] reg_byte(input logic [3:0] idx);
    if (idx <= REG_NOISE && $urandom_range(0, 1) == 1)
      return (idx[0] || idx == REG_NOISE) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 7));
    return 8'($urandom);
  endfunction

  function automatic bit steady();
    return send_q.size() < 150 || (send_q.size() / 100) % 3 == 0;
  endfunction

  // input side
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!held) begin
      if (gap_in > 0) begin
        push <= 1'b0;
        gap_in--;
      end else if (send_q.size() == 0) begin
        push <= 1'b0;
      end else if (send_q[0].drain && !drained) begin
        push <= 1'b0;
        if (owed.size() == 0) begin
          drained = 1'b1;
          gap_in = TAIL;
        end
      end else if (!steady() && $urandom_range(0, 9) == 0) begin
        push <= 1'b0;
        gap_in = $urandom_range(0, 11);
      end else begin
        push <= 1'b1;
        operation <= send_q[0].op;
        value <= send_q[0].val;
        drained = 1'b0;
      end
    end
  end

  // result side
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (gap_out > 0) begin
      pop <= 1'b0;
      gap_out--;
    end else if (!steady() && $urandom_range(0, 7) == 0) begin
      pop <= 1'b0;
      gap_out = $urandom_range(0, 11);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst) begin
      held <= push && full;
      if (pop && !empty) begin
        if (owed.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, got kind %0d read %02h sum %0d",
                   $time, result_kind, read_value, $signed(sample_sum));
        end else begin
          want = owed.pop_front();
          if (result_kind !== want.kind || read_value !== want.rd ||
              sample_sum !== want.sum) begin
            errors++;
            $display("%0t: mismatch, expected kind %0d read %02h sum %0d, got kind %0d read %02h sum %0d",
                     $time, want.kind, want.rd, $signed(want.sum),
                     result_kind, read_value, $signed(sample_sum));
          end
        end
      end
      if (push && !full) begin
        psg_apply(operation, value);
        void'(send_q.pop_front());
      end
      if ((push && !full) || (pop && !empty)) stalled = 0;
      else stalled++;
      if (stalled == STALL_LIMIT) begin
        $display("psg_tone_noise_sound_generator_unit_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int         next_pause;
    int         pick;
    logic [3:0] idx;
    for (int i = 0; i < 16; i++) regs[i] = 8'h00;
    for (int c = 0; c < 3; c++) tcnt[c] = 12'd0;
    tlev = 3'b000;
    sel = 4'd0;
    ncnt = 6'd0;
    nshift = NOISE_SEED;
    acc = 0;
    latch_a = 8'h00;
    bmode = MODE_OFF;
    next_pause = 400;

    add_word(OP_READ, 8'hFF);
    add_word(OP_TICK, 8'h00);
    add_word(OP_ADDR, {4'hF, 4'(REG_AMP)});
    add_word(OP_WRITE, 8'hFF);
    add_word(OP_ADDR, {4'h0, 4'(REG_AMP + 1)});
    add_word(OP_WRITE, 8'h0F);
    add_word(OP_ADDR, {4'hA, REG_A_LO});
    add_word(OP_WRITE, 8'h01);
    add_word(OP_ADDR, {4'h5, REG_C_HI});
    add_word(OP_WRITE, 8'hFF);
    repeat (2) add_word(OP_TICK, 8'hFF);
    add_word(OP_PORT_A, {4'hF, 4'(REG_NOISE)});
    add_word(OP_PORT_B, port_b(MODE_SELECT, 8'hFF));
    add_word(OP_PORT_B, port_b(MODE_SELECT, 8'h00));
    add_word(OP_PORT_A, 8'hFF);
    add_word(OP_PORT_B, port_b(MODE_WRITE, 8'h00));
    add_word(OP_PORT_B, port_b(MODE_OFF, 8'hFF));
    add_word(OP_PORT_B, port_b(MODE_HOLD, 8'h00));
    add_word(OP_READ, 8'h00);
    add_word(OP_SPARE_A, 8'hFF);
    add_word(OP_SPARE_B, 8'h00);
    add_word(OP_ADDR, {4'h0, 4'(REG_MIXER)});
    add_word(OP_WRITE, 8'h00);
    add_word(OP_TICK, 8'h00);
    add_word(OP_READ, 8'hFF);

    while (n_words < WORDS) begin
      if (n_words >= next_pause) begin
        hold_next = 1'b1;
        next_pause += 350;
      end
      pick = $urandom_range(0, 99);
      idx = 4'($urandom_range(0, 15));
      if (pick < 40) begin
        repeat ($urandom_range(1, 8)) add_word(OP_TICK, 8'($urandom));
      end else if (pick < 60) begin
        add_word(OP_ADDR, {4'($urandom), idx});
        add_word(OP_WRITE, reg_byte(idx));
      end else if (pick < 72) begin
        add_word(OP_PORT_A, {4'($urandom), idx});
        add_word(OP_PORT_B, port_b(MODE_SELECT, 8'($urandom)));
        add_word(OP_PORT_A, reg_byte(idx));
        add_word(OP_PORT_B, port_b(MODE_WRITE, 8'($urandom)));
        add_word(OP_PORT_B, port_b($urandom_range(0, 1) ? MODE_HOLD : MODE_OFF, 8'($urandom)));
        if ($urandom_range(0, 2) == 0) add_word(OP_READ, 8'($urandom));
      end else if (pick < 82) begin
        add_word(OP_ADDR, {4'($urandom), idx});
        add_word(OP_READ, 8'($urandom));
      end else if (pick < 90) begin
        add_word(3'($urandom), 8'($urandom));
      end else begin
        add_word($urandom_range(0, 1) ? OP_PORT_A : OP_PORT_B, 8'($urandom));
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    while (send_q.size() != 0 || owed.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (errors == 0) begin
      $display("psg_tone_noise_sound_generator_unit_tb: PASS");
    end else begin
      $display("psg_tone_noise_sound_generator_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
